### rtl/btbg_pkg.sv
package btbg_pkg;

   localparam int OP_W     = 2;
   localparam int FREQ_W   = 16;
   localparam int DUR_W    = 16;
   localparam int PERIOD_W = 20;
   localparam int CMP_W    = 19;
   localparam int LEFT_W   = 23;
   localparam int DIV_W    = 26;
   localparam int STEP_W   = $clog2(DIV_W);
   localparam int MS_W     = 10;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_TONE = 2'd1;
   localparam logic [OP_W-1:0] OP_BEEP = 2'd2;
   localparam logic [OP_W-1:0] OP_STOP = 2'd3;

   localparam logic [DIV_W-1:0]    TICKS_PER_SECOND = 26'd1000000;
   localparam logic [MS_W-1:0]     TICKS_PER_MS     = 10'd1000;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD     = 20'd1000;
   localparam logic [CMP_W-1:0]    RESET_COMPARE    = 19'd500;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [FREQ_W-1:0] freq_hz;
      logic [DUR_W-1:0]  length_ms;
   } req_type;

   typedef struct packed {
      logic              tone_level;
      logic              sounding;
      logic [LEFT_W-1:0] beep_periods_left;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_TONE,
      KIND_BEEP,
      KIND_STOP
   } kind_type;

   // Classified command as it sits in the queue between front and back.
   typedef struct packed {
      kind_type          kind;
      logic [FREQ_W-1:0] freq_hz;
      logic [DIV_W-1:0]  scaled_dur;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [PERIOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/btbg_front.sv
module btbg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  btbg_pkg::req_type req_data,
   output logic              head_valid,
   output btbg_pkg::cmd_type head_cmd,
   input  logic              head_pop
);
   import btbg_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    queue_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   cmd_type    cmd;

   // A zero frequency, or a beep of zero length, is just a stop.
   always_comb begin
      cmd.freq_hz    = req_data.freq_hz;
      cmd.scaled_dur = DIV_W'(req_data.length_ms) * DIV_W'(TICKS_PER_MS);
      unique case (req_data.operation)
         OP_TICK: cmd.kind = KIND_TICK;
         OP_TONE: cmd.kind = (req_data.freq_hz == '0) ? KIND_STOP : KIND_TONE;
         OP_BEEP: cmd.kind = (req_data.freq_hz == '0 || req_data.length_ms == '0)
                             ? KIND_STOP : KIND_BEEP;
         default: cmd.kind = KIND_STOP;
      endcase
   end

   assign req_ready  = (fill_ff != 2'(DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/btbg_divider.sv
module btbg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  btbg_pkg::div_req_type div_req,
   output btbg_pkg::div_rsp_type div_rsp
);
   import btbg_pkg::*;

   logic                busy_ff;
   logic                busy_in;
   logic                done_ff;
   logic                done_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [DIV_W-1:0]    quot_ff;
   logic [DIV_W-1:0]    quot_in;
   logic [PERIOD_W-1:0] rem_ff;
   logic [PERIOD_W-1:0] rem_in;
   logic [PERIOD_W-1:0] divisor_ff;
   logic [PERIOD_W-1:0] divisor_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;
   logic                fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial = {rem_ff, quot_ff[DIV_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DIV_W - 1);
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quot_in = {quot_ff[DIV_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

### rtl/btbg_back.sv
module btbg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  btbg_pkg::cmd_type     head_cmd,
   output logic                  head_pop,
   output btbg_pkg::div_req_type div_req,
   input  btbg_pkg::div_rsp_type div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output btbg_pkg::rsp_type     rsp_data
);
   import btbg_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PERIOD,
      S_COUNT,
      S_FINISH
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic [CMP_W-1:0]    compare_ff;
   logic [CMP_W-1:0]    compare_in;
   logic [PERIOD_W-1:0] tick_ff;
   logic [PERIOD_W-1:0] tick_in;
   logic [LEFT_W-1:0]   left_ff;
   logic [LEFT_W-1:0]   left_in;
   logic                on_ff;
   logic                on_in;
   logic                counting_ff;
   logic                counting_in;
   logic [PERIOD_W-1:0] calc_period_ff;
   logic [PERIOD_W-1:0] calc_period_in;
   logic [LEFT_W-1:0]   calc_count_ff;
   logic [LEFT_W-1:0]   calc_count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   // State after the head command, valid once its divisions are done.
   logic [PERIOD_W-1:0] a_period;
   logic [CMP_W-1:0]    a_compare;
   logic [PERIOD_W-1:0] a_tick;
   logic [LEFT_W-1:0]   a_left;
   logic                a_on;
   logic                a_counting;
   logic                wrap;
   logic                out_free;
   logic                commit;

   always_comb begin
      a_period   = period_ff;
      a_compare  = compare_ff;
      a_tick     = tick_ff;
      a_left     = left_ff;
      a_on       = on_ff;
      a_counting = counting_ff;
      wrap = (period_ff == '0) || ({1'b0, tick_ff} + 1'b1 >= {1'b0, period_ff});
      unique case (head_cmd.kind)
         KIND_TICK: begin
            if (on_ff) begin
               if (wrap) begin
                  a_tick = '0;
                  if (counting_ff && left_ff != '0) begin
                     a_left = left_ff - 1'b1;
                     if (left_ff == LEFT_W'(1)) begin
                        a_counting = 1'b0;
                        a_on       = 1'b0;
                     end
                  end
               end else begin
                  a_tick = tick_ff + 1'b1;
               end
            end
         end
         KIND_TONE: begin
            a_period   = calc_period_ff;
            a_compare  = calc_period_ff[PERIOD_W-1:1];
            a_tick     = '0;
            a_left     = '0;
            a_counting = 1'b0;
            a_on       = 1'b1;
         end
         KIND_BEEP: begin
            // A beep during a beep only stretches the budget.
            if (left_ff != '0) begin
               if (calc_count_ff > left_ff) begin
                  a_left = calc_count_ff;
               end
            end else begin
               a_period   = calc_period_ff;
               a_compare  = calc_period_ff[PERIOD_W-1:1];
               a_tick     = '0;
               a_left     = calc_count_ff;
               a_counting = 1'b1;
               a_on       = 1'b1;
            end
         end
         default: begin
            a_left     = '0;
            a_counting = 1'b0;
            a_on       = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      calc_period_in   = calc_period_ff;
      calc_count_in    = calc_count_ff;
      commit           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = TICKS_PER_SECOND;
      div_req.divisor  = PERIOD_W'(head_cmd.freq_hz);
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               if (head_cmd.kind == KIND_TONE || head_cmd.kind == KIND_BEEP) begin
                  div_req.start = 1'b1;
                  state_in      = S_PERIOD;
               end else if (out_free) begin
                  commit = 1'b1;
               end
            end
         end
         S_PERIOD: begin
            if (div_rsp.done) begin
               calc_period_in = div_rsp.quotient[PERIOD_W-1:0];
               if (head_cmd.kind == KIND_BEEP) begin
                  // Round to the nearest whole period.
                  div_req.start    = 1'b1;
                  div_req.dividend = head_cmd.scaled_dur
                                     + DIV_W'(div_rsp.quotient[PERIOD_W-1:1]);
                  div_req.divisor  = div_rsp.quotient[PERIOD_W-1:0];
                  state_in         = S_COUNT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_COUNT: begin
            if (div_rsp.done) begin
               calc_count_in = (div_rsp.quotient == '0) ? LEFT_W'(1)
                               : div_rsp.quotient[LEFT_W-1:0];
               state_in      = S_FINISH;
            end
         end
         default: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase

      period_in   = commit ? a_period   : period_ff;
      compare_in  = commit ? a_compare  : compare_ff;
      tick_in     = commit ? a_tick     : tick_ff;
      left_in     = commit ? a_left     : left_ff;
      on_in       = commit ? a_on       : on_ff;
      counting_in = commit ? a_counting : counting_ff;

      rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_data_in.tone_level        = a_on && (a_tick < PERIOD_W'(a_compare));
         rsp_data_in.sounding          = a_on;
         rsp_data_in.beep_periods_left = a_left;
      end
   end

   assign head_pop = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= RESET_PERIOD;
         compare_ff   <= RESET_COMPARE;
         tick_ff      <= '0;
         left_ff      <= '0;
         on_ff        <= 1'b0;
         counting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         tick_ff      <= tick_in;
         left_ff      <= left_in;
         on_ff        <= on_in;
         counting_ff  <= counting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      calc_period_ff <= calc_period_in;
      calc_count_ff  <= calc_count_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/buzzer_tone_beep_generator.sv
// Buzzer tone generator stepped by a 1 MHz tick, with timed beeps.
// The req_ channel carries one item per tick or command: a one-microsecond
// tick, a continuous tone, a timed beep, or a stop. The rsp_ channel returns
// exactly one item per request, in order, holding the pin level, whether the
// tone is enabled, and the whole periods a timed beep still owes.
// A front stage classifies each request and pre-scales the beep length to
// ticks; a two-entry queue decouples it from the back stage, which owns the
// tone state and a shared 26-step restoring divider.
// Ticks and stops sustain one item per cycle while the receiver takes results
// and no tone or beep is ahead; each passes the queue, then the output register.
// A tone waits for one pass through the one-bit-per-cycle divider, a beep for two.
// Reset (synchronous, active high) silences the output, clears the beep
// budget and counter, restores a period of 1000 ticks with compare at 500,
// and empties the queue and output register.
// When the receiver stalls, the finished result holds in the output
// register; the queue keeps accepting until its two entries are full, and
// req_ready then drops until the receiver takes a result.
module buzzer_tone_beep_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  btbg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btbg_pkg::rsp_type rsp_data
);
   import btbg_pkg::*;

   logic        head_valid;
   logic        head_pop;
   cmd_type     head_cmd;
   div_req_type div_req;
   div_rsp_type div_rsp;

   btbg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop)
   );

   btbg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   btbg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
